[rtl/core/smsc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smsc_pkg
// Shared constants, types and lookup functions for the shunt monitor setup
// calculator.
// ----------------------------------------------------------------------------
package smsc_pkg;

	localparam int TARGET_W = 31;
	localparam int RS_W     = 16;
	localparam int KIND_W   = 2;
	localparam int IDX_W    = 3;
	localparam int ACT_W    = 24;
	localparam int SC_W     = 18;
	localparam int CAL_W    = 16;
	localparam int WORD_W   = 16;
	localparam int REG_W    = 3;

	// scale = 244100 / rs, calibration = 512000000 / (scale * rs)
	localparam logic [SC_W-1:0] SCALE_NUM = SC_W'(244100);
	localparam int              CAL_NUM_W = 29;
	localparam logic [CAL_NUM_W-1:0] CAL_NUM = CAL_NUM_W'(512000000);
	// scale*rs stays above 178000 for any nonzero rs, so the quotient fits 12 bits
	localparam int CAL_Q_W = 12;

	localparam logic [2:0] MODE_BOTH = 3'd7;

	localparam int LAT_SEL   = 2;
	localparam int LAT_ARITH = SC_W + 1 + CAL_Q_W;

	typedef enum logic [KIND_W-1:0] {
		KIND_POWER = 2'd0,
		KIND_BUS   = 2'd1,
		KIND_CURR  = 2'd2,
		KIND_SHUNT = 2'd3
	} kind_t;

	localparam logic [REG_W-1:0] REG_SHUNT = 3'd1;
	localparam logic [REG_W-1:0] REG_BUS   = 3'd2;
	localparam logic [REG_W-1:0] REG_POWER = 3'd3;
	localparam logic [REG_W-1:0] REG_CURR  = 3'd4;

	typedef struct packed {
		logic [IDX_W-1:0]  time_index;
		logic [IDX_W-1:0]  avg_index;
		logic [ACT_W-1:0]  actual_us;
		logic [WORD_W-1:0] config_word;
		logic [REG_W-1:0]  read_register;
	} sel_res_t;

	function automatic logic [13:0] conv_us(input logic [IDX_W-1:0] i);
		case (i)
			3'd0:    conv_us = 14'd140;
			3'd1:    conv_us = 14'd204;
			3'd2:    conv_us = 14'd332;
			3'd3:    conv_us = 14'd588;
			3'd4:    conv_us = 14'd1100;
			3'd5:    conv_us = 14'd2116;
			3'd6:    conv_us = 14'd4156;
			default: conv_us = 14'd8244;
		endcase
	endfunction

	// averaging counts are powers of two: 1,4,16,64,128,256,512,1024
	function automatic logic [3:0] avg_shift(input logic [IDX_W-1:0] i);
		case (i)
			3'd0:    avg_shift = 4'd0;
			3'd1:    avg_shift = 4'd2;
			3'd2:    avg_shift = 4'd4;
			3'd3:    avg_shift = 4'd6;
			3'd4:    avg_shift = 4'd7;
			3'd5:    avg_shift = 4'd8;
			3'd6:    avg_shift = 4'd9;
			default: avg_shift = 4'd10;
		endcase
	endfunction

	function automatic logic [REG_W-1:0] reg_of_kind(input kind_t k);
		case (k)
			KIND_POWER: reg_of_kind = REG_POWER;
			KIND_BUS:   reg_of_kind = REG_BUS;
			KIND_CURR:  reg_of_kind = REG_CURR;
			KIND_SHUNT: reg_of_kind = REG_SHUNT;
			default:    reg_of_kind = REG_POWER;
		endcase
	endfunction

endpackage

[rtl/core/shunt_monitor_setup_calc_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shunt_monitor_setup_calc_unit
// Turns a target integration time, shunt resistance and sensor kind into
// the monitor presets, scale, calibration and configuration word.
// ----------------------------------------------------------------------------
// One transaction in per cycle while in_stall is low, one result out per
// transaction. The pipeline is made of the two restoring dividers (18 scale bits, then
// 12 calibration bits, one bit per stage) and the product stage between them.
// A stall on the output freezes the whole pipeline and is passed straight to
// in_stall when the last stage holds a result.
module shunt_monitor_setup_calc_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [smsc_pkg::TARGET_W-1:0]  target_time,
	input  logic [smsc_pkg::RS_W-1:0]      shunt_mohm,
	input  logic [smsc_pkg::KIND_W-1:0]    sensor_kind,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [smsc_pkg::IDX_W-1:0]     time_index,
	output logic [smsc_pkg::IDX_W-1:0]     avg_index,
	output logic [smsc_pkg::ACT_W-1:0]     actual_us,
	output logic [smsc_pkg::SC_W-1:0]      current_scale,
	output logic [smsc_pkg::CAL_W-1:0]     calibration,
	output logic [smsc_pkg::WORD_W-1:0]    config_word,
	output logic [smsc_pkg::REG_W-1:0]     read_register,
	output logic                           error
);
	import smsc_pkg::*;

	localparam int DLY = LAT_ARITH - LAT_SEL;

	logic     en;
	logic     v_last;
	sel_res_t sel_res;
	sel_res_t sd_s [0:DLY];

	assign en       = !(v_last && out_stall);
	assign in_stall = v_last && out_stall;

	smsc_sel u_sel (
		.clk         (clk),
		.en          (en),
		.target_time (target_time),
		.sensor_kind (sensor_kind),
		.res         (sel_res)
	);

	smsc_arith u_arith (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_v       (in_valid),
		.shunt_mohm (shunt_mohm),
		.out_v      (v_last),
		.scale      (current_scale),
		.cal        (calibration),
		.err        (error)
	);

	// align the preset results with the divider pipeline
	assign sd_s[0] = sel_res;
	for (genvar k = 0; k < DLY; k++) begin : g_dly
		always_ff @(posedge clk) begin
			if (en)
				sd_s[k+1] <= sd_s[k];
		end
	end

	assign out_valid     = v_last;
	assign time_index    = sd_s[DLY].time_index;
	assign avg_index     = sd_s[DLY].avg_index;
	assign actual_us     = sd_s[DLY].actual_us;
	assign config_word   = sd_s[DLY].config_word;
	assign read_register = sd_s[DLY].read_register;

endmodule

[rtl/core/smsc_sel.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smsc_sel
// Two-stage preset selection: conversion time, then averaging count, plus
// the packed configuration word and poll register.
// ----------------------------------------------------------------------------
module smsc_sel (
	input  logic                          clk,
	input  logic                          en,
	input  logic [smsc_pkg::TARGET_W-1:0] target_time,
	input  logic [smsc_pkg::KIND_W-1:0]   sensor_kind,
	output smsc_pkg::sel_res_t            res
);
	import smsc_pkg::*;

	logic [IDX_W-1:0]    t_c;
	logic [IDX_W-1:0]    t_s1;
	logic [TARGET_W-1:0] target_s1;
	logic [KIND_W-1:0]   kind_s1;
	logic [IDX_W-1:0]    a_c;
	logic [ACT_W-1:0]    actual_c;
	sel_res_t            res_s2;

	// presets are increasing, so the index is the count of presets above the first that fit
	always_comb begin
		t_c = '0;
		for (int i = 1; i < 8; i++) begin
			if (TARGET_W'(conv_us(IDX_W'(i))) <= target_time)
				t_c = t_c + IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1      <= t_c;
			target_s1 <= target_time;
			kind_s1   <= sensor_kind;
		end
	end

	always_comb begin
		a_c = '0;
		for (int i = 1; i < 8; i++) begin
			if ((TARGET_W'(conv_us(t_s1)) << avg_shift(IDX_W'(i))) <= target_s1)
				a_c = a_c + IDX_W'(1);
		end
		actual_c = ACT_W'(conv_us(t_s1)) << avg_shift(a_c);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s2.time_index    <= t_s1;
			res_s2.avg_index     <= a_c;
			res_s2.actual_us     <= actual_c;
			res_s2.config_word   <= {4'd0, a_c, t_s1, t_s1, MODE_BOTH};
			res_s2.read_register <= reg_of_kind(kind_t'(kind_s1));
		end
	end

	assign res = res_s2;

endmodule

[rtl/core/smsc_arith.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smsc_arith
// Pipelined scale divider, product stage and calibration divider, one
// quotient bit per stage. Valid bits travel along with the data.
// ----------------------------------------------------------------------------
module smsc_arith (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_v,
	input  logic [smsc_pkg::RS_W-1:0] shunt_mohm,
	output logic                      out_v,
	output logic [smsc_pkg::SC_W-1:0] scale,
	output logic [smsc_pkg::CAL_W-1:0] cal,
	output logic                      err
);
	import smsc_pkg::*;

	localparam int SD_W = SC_W + RS_W;
	localparam int CD_W = CAL_NUM_W + CAL_Q_W;

	logic [LAT_ARITH:0] v_s;

	// scale divider
	logic [SC_W-1:0] srem_s [0:SC_W];
	logic [SC_W-1:0] squo_s [0:SC_W];
	logic [RS_W-1:0] srs_s  [0:SC_W];

	// product stage
	logic [SC_W-1:0] prod_s;
	logic [SC_W-1:0] pscale_s;
	logic            perr_s;

	// calibration divider
	logic [CAL_NUM_W-1:0] crem_s [0:CAL_Q_W];
	logic [CAL_Q_W-1:0]   cquo_s [0:CAL_Q_W];
	logic [SC_W-1:0]      cdiv_s [0:CAL_Q_W];
	logic [SC_W-1:0]      cscale_s [0:CAL_Q_W];
	logic                 cerr_s [0:CAL_Q_W];

	assign v_s[0]    = in_v;
	assign srem_s[0] = SCALE_NUM;
	assign squo_s[0] = '0;
	assign srs_s[0]  = shunt_mohm;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[LAT_ARITH:1] <= '0;
		end else if (en) begin
			v_s[LAT_ARITH:1] <= v_s[LAT_ARITH-1:0];
		end
	end

	for (genvar j = 0; j < SC_W; j++) begin : g_sdiv
		logic [SD_W-1:0] dsh;
		logic            ge;
		assign dsh = SD_W'(srs_s[j]) << (SC_W-1-j);
		assign ge  = SD_W'(srem_s[j]) >= dsh;
		always_ff @(posedge clk) begin
			if (en) begin
				srem_s[j+1] <= ge ? SC_W'(SD_W'(srem_s[j]) - dsh) : srem_s[j];
				squo_s[j+1] <= squo_s[j] | (SC_W'(ge) << (SC_W-1-j));
				srs_s[j+1]  <= srs_s[j];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s   <= SC_W'(squo_s[SC_W] * srs_s[SC_W]);
			pscale_s <= squo_s[SC_W];
			perr_s   <= (srs_s[SC_W] == '0) || (squo_s[SC_W] == '0);
		end
	end

	assign crem_s[0]   = CAL_NUM;
	assign cquo_s[0]   = '0;
	assign cdiv_s[0]   = prod_s;
	assign cscale_s[0] = pscale_s;
	assign cerr_s[0]   = perr_s;

	for (genvar j = 0; j < CAL_Q_W; j++) begin : g_cdiv
		logic [CD_W-1:0] dsh;
		logic            ge;
		assign dsh = CD_W'(cdiv_s[j]) << (CAL_Q_W-1-j);
		assign ge  = CD_W'(crem_s[j]) >= dsh;
		always_ff @(posedge clk) begin
			if (en) begin
				crem_s[j+1]   <= ge ? CAL_NUM_W'(CD_W'(crem_s[j]) - dsh) : crem_s[j];
				cquo_s[j+1]   <= cquo_s[j] | (CAL_Q_W'(ge) << (CAL_Q_W-1-j));
				cdiv_s[j+1]   <= cdiv_s[j];
				cscale_s[j+1] <= cscale_s[j];
				cerr_s[j+1]   <= cerr_s[j];
			end
		end
	end

	assign out_v = v_s[LAT_ARITH];
	assign err   = cerr_s[CAL_Q_W];
	assign scale = cerr_s[CAL_Q_W] ? '0 : cscale_s[CAL_Q_W];
	assign cal   = cerr_s[CAL_Q_W] ? '0 : CAL_W'(cquo_s[CAL_Q_W]);

endmodule

[rtl/core/smsc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smsc_checker
// Port-level checks for the shunt monitor setup calculator.
// ----------------------------------------------------------------------------
module smsc_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [smsc_pkg::IDX_W-1:0]    time_index,
	input logic [smsc_pkg::IDX_W-1:0]    avg_index,
	input logic [smsc_pkg::SC_W-1:0]     current_scale,
	input logic [smsc_pkg::CAL_W-1:0]    calibration,
	input logic [smsc_pkg::WORD_W-1:0]   config_word,
	input logic [smsc_pkg::REG_W-1:0]    read_register,
	input logic                          error
);
	import smsc_pkg::*;

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(config_word) && $stable(calibration))
		else $error("stalled result changed");

	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output stall");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error |-> current_scale == '0 && calibration == '0)
		else $error("error result carries nonzero scale or calibration");

	a_word_pack: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> config_word[2:0] == MODE_BOTH && config_word[5:3] == time_index
			&& config_word[8:6] == time_index && config_word[11:9] == avg_index
			&& config_word[15:12] == 4'd0)
		else $error("config word does not match indices");

	a_read_reg: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> read_register == REG_SHUNT || read_register == REG_BUS
			|| read_register == REG_POWER || read_register == REG_CURR)
		else $error("bad poll register");

endmodule

bind shunt_monitor_setup_calc_unit smsc_checker u_smsc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.time_index    (time_index),
	.avg_index     (avg_index),
	.current_scale (current_scale),
	.calibration   (calibration),
	.config_word   (config_word),
	.read_register (read_register),
	.error         (error)
);
